/* rtl/core/wac_pkg.sv */
// Shared types and default constants of the window absolute correlation unit.
package wac_pkg;

  localparam int WAC_MAX_WINDOW           = 512;
  localparam int WAC_SAMPLE_BITS          = 16;
  localparam int WAC_RESULT_FRACTION_BITS = 15;

  localparam int WAC_FIELD_BITS  = 16;
  localparam int WAC_CORR_BITS   = 16;
  localparam int WAC_LENGTH_BITS = 10;

  // Products formed by the shared multiplier after a window closes, in order.
  typedef enum logic [2:0] {
    STEP_N_SAA = 3'd0,
    STEP_SA_SQ = 3'd1,
    STEP_N_SBB = 3'd2,
    STEP_SB_SQ = 3'd3,
    STEP_N_SAB = 3'd4,
    STEP_SA_SB = 3'd5,
    STEP_DEN   = 3'd6,
    STEP_LIM   = 3'd7
  } step_e;

  typedef struct packed {
    logic  capture;
    logic  mul_load;
    logic  mul_step;
    logic  mul_store;
    step_e step;
    logic  root_init;
    logic  root_add1;
    logic  root_add2;
    logic  root_cmp;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic den_zero;
  } status_t;

endpackage

/* rtl/core/wac_ctrl.sv */
// Sequencer of the window absolute correlation unit.
module wac_ctrl import wac_pkg::*; #(
  parameter int MUL_W                = 53,
  parameter int RESULT_FRACTION_BITS = WAC_RESULT_FRACTION_BITS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  localparam int F   = RESULT_FRACTION_BITS;
  localparam int MCW = $clog2(MUL_W);
  localparam int BCW = $clog2(F + 1);

  typedef enum logic [9:0] {
    ST_ACC    = 10'b0000000001,
    ST_DRAIN  = 10'b0000000010,
    ST_MLOAD  = 10'b0000000100,
    ST_MRUN   = 10'b0000001000,
    ST_MSTORE = 10'b0000010000,
    ST_RINIT  = 10'b0000100000,
    ST_RADD1  = 10'b0001000000,
    ST_RADD2  = 10'b0010000000,
    ST_RCMP   = 10'b0100000000,
    ST_FIN    = 10'b1000000000
  } state_e;

  state_e           state_q, state_d;
  step_e            step_q, step_d;
  logic [MCW-1:0]   mul_cnt_q, mul_cnt_d;
  logic [BCW-1:0]   bit_cnt_q, bit_cnt_d;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    mul_cnt_d = mul_cnt_q;
    bit_cnt_d = bit_cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_ACC: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        step_d  = STEP_N_SAA;
        state_d = ST_MLOAD;
      end
      ST_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        mul_cnt_d      = '0;
        state_d        = ST_MRUN;
      end
      ST_MRUN: begin
        cmd_o.mul_step = 1'b1;
        if (mul_cnt_q == MCW'(MUL_W - 1)) begin
          state_d = ST_MSTORE;
        end else begin
          mul_cnt_d = mul_cnt_q + 1'b1;
        end
      end
      ST_MSTORE: begin
        cmd_o.mul_store = 1'b1;
        if (step_q == STEP_LIM) begin
          state_d = ST_RINIT;
        end else begin
          step_d  = step_e'(3'(step_q + 3'd1));
          state_d = ST_MLOAD;
        end
      end
      ST_RINIT: begin
        cmd_o.root_init = 1'b1;
        bit_cnt_d       = BCW'(F);
        state_d         = status_i.den_zero ? ST_FIN : ST_RADD1;
      end
      ST_RADD1: begin
        cmd_o.root_add1 = 1'b1;
        state_d         = ST_RADD2;
      end
      ST_RADD2: begin
        cmd_o.root_add2 = 1'b1;
        state_d         = ST_RCMP;
      end
      ST_RCMP: begin
        cmd_o.root_cmp = 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
          state_d   = ST_RADD1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACC;
      step_q    <= STEP_N_SAA;
      mul_cnt_q <= '0;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      mul_cnt_q <= mul_cnt_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i && in_last_i) |=> !in_ready_o)
    else $error("input taken right after a last item");

  a_load_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MLOAD) |=> (state_q == ST_MRUN && mul_cnt_q == '0))
    else $error("multiplier load not followed by a run");

  a_root_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MSTORE && step_q == STEP_LIM) |=> (state_q == ST_RINIT))
    else $error("root search did not start after last product");

  a_bit_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RCMP && bit_cnt_q != '0) |=> (state_q == ST_RADD1))
    else $error("root search ended early");

endmodule

/* rtl/core/wac_datapath.sv */
// Accumulators, shared serial multiplier and root search of the correlation unit.
module wac_datapath import wac_pkg::*; #(
  parameter int MAX_WINDOW           = WAC_MAX_WINDOW,
  parameter int SAMPLE_BITS          = WAC_SAMPLE_BITS,
  parameter int RESULT_FRACTION_BITS = WAC_RESULT_FRACTION_BITS,
  parameter int MUL_W                = 53
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic [WAC_FIELD_BITS-1:0]  channel_sample_i,
  input  logic [WAC_FIELD_BITS-1:0]  target_sample_i,
  output logic [WAC_CORR_BITS-1:0]   correlation_o,
  output logic [WAC_LENGTH_BITS-1:0] window_length_o,
  output logic                       window_overflow_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i
);

  localparam int SW   = SAMPLE_BITS;
  localparam int F    = RESULT_FRACTION_BITS;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SW + CW;
  localparam int SQW  = 2 * SW + CW;
  localparam int PW   = 2 * MUL_W;
  localparam int WW   = 2 * MUL_W + 2 * F + 4;

  // sample register in front of the accumulators
  logic                   pipe_valid_q;
  logic signed [SW-1:0]   pa_q, pb_q;
  logic [SW-1:0]          raw_a, raw_b;

  logic signed [SUMW-1:0] sum_a_q, sum_b_q;
  logic [SQW-1:0]         sum_aa_q, sum_bb_q;
  logic signed [SQW-1:0]  sum_ab_q;
  logic [CW-1:0]          count_q;
  logic                   ovf_q;

  logic signed [2*SW-1:0] paa, pbb, pab;

  assign raw_a = SW'(channel_sample_i);
  assign raw_b = SW'(target_sample_i);
  assign paa   = pa_q * pa_q;
  assign pbb   = pb_q * pb_q;
  assign pab   = pa_q * pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else begin
      pipe_valid_q <= cmd_i.capture;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pa_q <= raw_a;
      pb_q <= raw_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      sum_aa_q <= '0;
      sum_bb_q <= '0;
      sum_ab_q <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (cmd_i.finish) begin
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      sum_aa_q <= '0;
      sum_bb_q <= '0;
      sum_ab_q <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (pipe_valid_q) begin
      if (count_q < CW'(MAX_WINDOW)) begin
        sum_a_q  <= sum_a_q + SUMW'(pa_q);
        sum_b_q  <= sum_b_q + SUMW'(pb_q);
        sum_aa_q <= sum_aa_q + SQW'($unsigned(paa));
        sum_bb_q <= sum_bb_q + SQW'($unsigned(pbb));
        sum_ab_q <= sum_ab_q + SQW'(pab);
        count_q  <= count_q + 1'b1;
      end else begin
        // full window: drop the pair
        ovf_q <= 1'b1;
      end
    end
  end

  logic [SUMW-1:0] abs_a, abs_b;
  logic [SQW-1:0]  abs_ab;
  logic            sign_p, sign_q;

  assign abs_a  = sum_a_q[SUMW-1] ? $unsigned(-sum_a_q) : $unsigned(sum_a_q);
  assign abs_b  = sum_b_q[SUMW-1] ? $unsigned(-sum_b_q) : $unsigned(sum_b_q);
  assign abs_ab = sum_ab_q[SQW-1] ? $unsigned(-sum_ab_q) : $unsigned(sum_ab_q);
  assign sign_p = sum_ab_q[SQW-1];
  assign sign_q = sum_a_q[SUMW-1] ^ sum_b_q[SUMW-1];

  // shift-add multiplier, one multiplier bit per cycle
  logic [PW-1:0]    mul_a_q, prod_q;
  logic [MUL_W-1:0] mul_b_q;
  logic [MUL_W-1:0] op_a, op_b;
  logic [MUL_W-1:0] t1_q, va_q, vb_q, num_q;
  logic [PW-1:0]    den_q;
  logic [WW-1:0]    lim_q;
  logic [PW-1:0]    t1_ext;

  assign t1_ext = PW'(t1_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd_i.step)
      STEP_N_SAA: begin
        op_a = MUL_W'(count_q);
        op_b = MUL_W'(sum_aa_q);
      end
      STEP_SA_SQ: begin
        op_a = MUL_W'(abs_a);
        op_b = MUL_W'(abs_a);
      end
      STEP_N_SBB: begin
        op_a = MUL_W'(count_q);
        op_b = MUL_W'(sum_bb_q);
      end
      STEP_SB_SQ: begin
        op_a = MUL_W'(abs_b);
        op_b = MUL_W'(abs_b);
      end
      STEP_N_SAB: begin
        op_a = MUL_W'(count_q);
        op_b = MUL_W'(abs_ab);
      end
      STEP_SA_SB: begin
        op_a = MUL_W'(abs_a);
        op_b = MUL_W'(abs_b);
      end
      STEP_DEN: begin
        op_a = va_q;
        op_b = vb_q;
      end
      STEP_LIM: begin
        op_a = num_q;
        op_b = num_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mul_a_q <= PW'(op_a);
      mul_b_q <= op_b;
      prod_q  <= '0;
    end else if (cmd_i.mul_step) begin
      if (mul_b_q[0]) begin
        prod_q <= prod_q + mul_a_q;
      end
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_store) begin
      unique case (cmd_i.step) inside
        STEP_N_SAA, STEP_N_SBB, STEP_N_SAB: begin
          t1_q <= MUL_W'(prod_q);
        end
        STEP_SA_SQ: begin
          va_q <= (t1_ext >= prod_q) ? MUL_W'(t1_ext - prod_q) : '0;
        end
        STEP_SB_SQ: begin
          vb_q <= (t1_ext >= prod_q) ? MUL_W'(t1_ext - prod_q) : '0;
        end
        STEP_SA_SB: begin
          if (sign_p != sign_q) begin
            num_q <= MUL_W'(t1_ext + prod_q);
          end else if (t1_ext >= prod_q) begin
            num_q <= MUL_W'(t1_ext - prod_q);
          end else begin
            num_q <= MUL_W'(prod_q - t1_ext);
          end
        end
        STEP_DEN: begin
          den_q <= prod_q;
        end
        STEP_LIM: begin
          lim_q <= WW'(prod_q) << (2 * F);
        end
        default: begin
          t1_q <= t1_q;
        end
      endcase
    end
  end

  // bitwise root search: y = r^2*den, xs = r*den*2^(b+1), d2 = den*2^(2b)
  logic [WW-1:0] y_q, xs_q, d2_q, tsum_q, xs_next;
  logic [F:0]    r_q, rbit_q;

  assign xs_next = (tsum_q <= lim_q) ? (xs_q + (d2_q << 1)) : xs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      y_q    <= '0;
      xs_q   <= '0;
      d2_q   <= WW'(den_q) << (2 * F);
      r_q    <= '0;
      rbit_q <= {1'b1, F'(0)};
    end else if (cmd_i.root_add1) begin
      tsum_q <= y_q + xs_q;
    end else if (cmd_i.root_add2) begin
      tsum_q <= tsum_q + d2_q;
    end else if (cmd_i.root_cmp) begin
      if (tsum_q <= lim_q) begin
        y_q <= tsum_q;
        r_q <= r_q | rbit_q;
      end
      xs_q   <= xs_next >> 1;
      d2_q   <= d2_q >> 2;
      rbit_q <= rbit_q >> 1;
    end
  end

  // output register
  logic                       out_valid_q;
  logic [WAC_CORR_BITS-1:0]   corr_q;
  logic [WAC_LENGTH_BITS-1:0] len_q;
  logic                       ovf_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      corr_q    <= WAC_CORR_BITS'(r_q);
      len_q     <= WAC_LENGTH_BITS'(count_q);
      ovf_out_q <= ovf_q;
    end
  end

  assign correlation_o     = corr_q;
  assign window_length_o   = len_q;
  assign window_overflow_o = ovf_out_q;
  assign out_valid_o       = out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.den_zero = (den_q == '0);

endmodule

/* rtl/core/window_abs_correlation_unit.sv */
// Top level of the window absolute correlation unit.
//
// Input stream: one item per pair of a channel sample and a target sample;
// tlast marks the final pair of a window. Items are taken one per cycle while
// a window accumulates. After the last item the block deasserts s_axis_tready
// and computes |n*Sab - Sa*Sb| / sqrt((n*Saa - Sa^2)(n*Sbb - Sb^2)) with one
// shared shift-add multiplier (one bit per cycle) and a bitwise root search
// (two additions and a compare per result bit); a zero denominator skips the
// root search.
// Output stream: one item per window with correlation and window length in
// tdata and the overflow flag in tuser. The result sits in an output register;
// the next window is accepted while it waits. A stalled receiver only holds
// the block when the following window finishes before the result is taken.
// Reset clears all sums, the pair count, the flag and both valid signals.
// Pairs beyond MAX_WINDOW are dropped and set the overflow flag.
module window_abs_correlation_unit import wac_pkg::*; #(
  parameter int MAX_WINDOW           = WAC_MAX_WINDOW,
  parameter int SAMPLE_BITS          = WAC_SAMPLE_BITS,
  parameter int RESULT_FRACTION_BITS = WAC_RESULT_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // channel_sample[15:0], target_sample[31:16]
  input  logic        s_axis_tlast,  // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // correlation[15:0], window_length[25:16], zero
  output logic        m_axis_tuser   // window_overflow
);

  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int VW    = 2 * SAMPLE_BITS + 2 * CW;
  localparam int MUL_W = VW + 1;

  cmd_t    cmd;
  status_t status;

  logic [WAC_CORR_BITS-1:0]   correlation;
  logic [WAC_LENGTH_BITS-1:0] window_length;

  wac_ctrl #(
    .MUL_W                (MUL_W),
    .RESULT_FRACTION_BITS (RESULT_FRACTION_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  wac_datapath #(
    .MAX_WINDOW           (MAX_WINDOW),
    .SAMPLE_BITS          (SAMPLE_BITS),
    .RESULT_FRACTION_BITS (RESULT_FRACTION_BITS),
    .MUL_W                (MUL_W)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .channel_sample_i  (s_axis_tdata[15:0]),
    .target_sample_i   (s_axis_tdata[31:16]),
    .correlation_o     (correlation),
    .window_length_o   (window_length),
    .window_overflow_o (m_axis_tuser),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, window_length, correlation};

endmodule
